FILE: sv/deque_with_reverse_assert.svh
// Assertion macros shared by the deque checker.
`ifndef DEQUE_WITH_REVERSE_ASSERT_SVH
`define DEQUE_WITH_REVERSE_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define DWR_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deque check failed");

// Next-cycle implication, ignored while reset is high.
`define DWR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deque check failed");

// Condition that must hold in the cycle after reset is seen.
`define DWR_ASSERT_RST(name, cons) \
  name: assert property (@(posedge clk) rst |=> (cons)) \
    else $error("deque check failed");

`endif

FILE: sv/dwr_pkg.sv
// Shared types and codes for the deque with reverse.
package dwr_pkg;

  // Opcodes of an input word.
  localparam logic [1:0] OP_INS_HEAD = 2'd0;
  localparam logic [1:0] OP_INS_TAIL = 2'd1;
  localparam logic [1:0] OP_REM_HEAD = 2'd2;
  localparam logic [1:0] OP_REVERSE  = 2'd3;

  // Number of decoded commands held between the front and the back.
  localparam int unsigned CMDQ_DEPTH = 2;

  // A decoded command as it travels from the front to the back.
  typedef struct packed {
    logic               ins;   // insert a value
    logic               head;  // insert at the logical head (else tail)
    logic               rem;   // remove from the logical head
    logic               rev;   // toggle the order
    logic signed [31:0] value;
  } cmd_t;

endpackage

FILE: sv/dwr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module dwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/dwr_front.sv
// Front end: accepts input words, decodes them and buffers the commands.
module dwr_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           opcode,
  input  logic signed [31:0]   value,
  output logic                 q_valid,
  output dwr_pkg::cmd_t        q_cmd,
  input  logic                 q_deq
);

  localparam int PW = $clog2(dwr_pkg::CMDQ_DEPTH);
  localparam int CW = $clog2(dwr_pkg::CMDQ_DEPTH + 1);

  dwr_pkg::cmd_t  slots [dwr_pkg::CMDQ_DEPTH];
  dwr_pkg::cmd_t  dec;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  fill;
  logic           enq;
  logic           deq;

  // Decode the opcode into command flags.
  always_comb begin
    dec       = '0;
    dec.value = value;
    case (opcode)
      dwr_pkg::OP_INS_HEAD: begin
        dec.ins  = 1'b1;
        dec.head = 1'b1;
      end
      dwr_pkg::OP_INS_TAIL: begin
        dec.ins  = 1'b1;
      end
      dwr_pkg::OP_REM_HEAD: begin
        dec.rem  = 1'b1;
      end
      dwr_pkg::OP_REVERSE: begin
        dec.rev  = 1'b1;
      end
      default: begin
        dec.rev  = 1'b1;
      end
    endcase
  end

  assign in_ready = (fill != CW'(dwr_pkg::CMDQ_DEPTH));
  assign enq      = in_valid && in_ready;
  assign q_valid  = (fill != '0);
  assign deq      = q_deq && q_valid;
  assign q_cmd    = slots[rd_ptr];

  // Command slots.
  always_ff @(posedge clk) begin
    if (enq) begin
      slots[wr_ptr] <= dec;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= (wr_ptr == PW'(dwr_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= (rd_ptr == PW'(dwr_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (enq && !deq) begin
        fill <= fill + 1'b1;
      end else if (deq && !enq) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

FILE: sv/dwr_back.sv
// Back end: executes commands on the ring buffer and holds the result word.
module dwr_back #(
  parameter int DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  dwr_pkg::cmd_t       q_cmd,
  output logic                q_deq,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                success,
  output logic signed [31:0]  removed_value,
  output logic [4:0]          occupancy
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Pointer state.
  logic [AW-1:0] front;
  logic [AW-1:0] front_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          reversed;
  logic          reversed_next;
  logic          pend;
  logic          pend_next;

  // RAM ports.
  logic          we;
  logic [AW-1:0] waddr;
  logic          re;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  // Result load.
  logic          load;
  logic          load_ok;
  logic [31:0]   load_val;

  logic          take;
  logic          full;
  logic          empty;
  logic [AW-1:0] prev_pos;
  logic [AW-1:0] next_pos;
  logic [SW-1:0] tail_sum;
  logic [SW-1:0] last_sum;
  logic [AW-1:0] tail_pos;
  logic [AW-1:0] last_pos;

  dwr_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (q_cmd.value),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Ring positions around the stored elements.
  assign prev_pos = (front == '0) ? AW'(DEPTH - 1) : front - 1'b1;
  assign next_pos = (front == AW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign tail_sum = SW'(front) + SW'(count);
  assign last_sum = tail_sum - 1'b1;
  assign tail_pos = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
  assign last_pos = (last_sum >= SW'(DEPTH)) ? AW'(last_sum - SW'(DEPTH)) : AW'(last_sum);

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  // A command is taken when no read is pending and the result slot frees up.
  assign take  = q_valid && !pend && (!out_valid || out_ready);
  assign q_deq = take;

  // Command execution.
  always_comb begin
    front_next    = front;
    count_next    = count;
    reversed_next = reversed;
    pend_next     = 1'b0;
    we            = 1'b0;
    waddr         = tail_pos;
    re            = 1'b0;
    raddr         = front;
    load          = 1'b0;
    load_ok       = 1'b0;
    load_val      = '0;
    if (pend) begin
      // The head value read last cycle completes the remove.
      load     = 1'b1;
      load_ok  = 1'b1;
      load_val = rdata;
    end else if (take) begin
      if (q_cmd.ins) begin
        load = 1'b1;
        if (!full) begin
          load_ok    = 1'b1;
          we         = 1'b1;
          count_next = count + 1'b1;
          if (q_cmd.head != reversed) begin
            front_next = prev_pos;
            waddr      = prev_pos;
          end
        end
      end else if (q_cmd.rem) begin
        if (empty) begin
          load = 1'b1;
        end else begin
          re         = 1'b1;
          pend_next  = 1'b1;
          count_next = count - 1'b1;
          if (reversed) begin
            raddr = last_pos;
          end else begin
            front_next = next_pos;
          end
        end
      end else begin
        load          = 1'b1;
        load_ok       = 1'b1;
        reversed_next = !reversed;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      reversed  <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      front    <= front_next;
      count    <= count_next;
      reversed <= reversed_next;
      pend     <= pend_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (load) begin
      success       <= load_ok;
      removed_value <= load_val;
      occupancy     <= 5'(count_next);
    end
  end

endmodule

FILE: sv/deque_with_reverse.sv
// Top level of the bounded double-ended queue with order reversal.
//
//   channel  signals                             role
//   in       in_valid, in_ready, opcode, value   operation word into the deque
//   out      out_valid, out_ready, success,      one result word per operation
//            removed_value, occupancy
//
// A word is held in the command queue of the front end after it is accepted, and the
// back end runs it from there: the result word of an insert or a reverse is registered
// from the queue, that of a remove passes also through the registered read port of
// the entry RAM. Sustained rate is one word per cycle without removes while the output
// is not stalled; a remove holds off the next command until its read completes.
// Reset clears pointers, count, order flag and both queues; the entry RAM keeps
// its contents, so no clearing pass runs. A stalled output holds the back end,
// while the front end keeps taking words until its two-entry queue is full.
module deque_with_reverse #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               success,
  output logic signed [31:0] removed_value,
  output logic [4:0]         occupancy
);

  logic          q_valid;
  logic          q_deq;
  dwr_pkg::cmd_t q_cmd;

  // Decode and buffer.
  dwr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .value    (value),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_deq    (q_deq)
  );

  // Execute on the ring buffer.
  dwr_back #(.DEPTH(DEPTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_deq         (q_deq),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .removed_value (removed_value),
    .occupancy     (occupancy)
  );

endmodule

FILE: sv/dwr_checker.sv
// Port-level checks for the deque, bound to the top level.
`include "deque_with_reverse_assert.svh"

module dwr_checker #(
  parameter int DEPTH = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               success,
  input logic signed [31:0] removed_value,
  input logic [4:0]         occupancy
);

  // Reset empties both queues.
  `DWR_ASSERT_RST(a_reset_idle, !out_valid && in_ready)

  // A failed operation reports a zero value.
  `DWR_ASSERT_NOW(a_fail_zero, out_valid && !success, removed_value == '0)

  // Occupancy never exceeds the store size.
  `DWR_ASSERT_NOW(a_occ_bound, out_valid, 32'(occupancy) <= 32'(DEPTH))

  // A stalled result holds.
  `DWR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(success) && $stable(removed_value) && $stable(occupancy))

endmodule

bind deque_with_reverse dwr_checker #(.DEPTH(DEPTH)) u_dwr_checker (.*);

FILE: sim/tb_deque_with_reverse.sv
// Self-checking testbench for the deque with reverse: predictor, checker and stimulus.
`timescale 1ns / 1ps

// Tracks the deque contents and checks each result word against the prediction.
class deque_answer_checker;
  typedef struct packed {
    logic               ok;
    logic signed [31:0] taken;
    logic [4:0]         held;
  } answer_t;

  localparam int SLOTS = 16;

  logic [31:0] slot_value[SLOTS];
  logic [3:0]  front_slot;
  logic [4:0]  held_count;
  logic        order_flipped;
  answer_t     awaited_answers[$];

  int errors;
  int words_seen;
  int refused_full;
  int refused_empty;
  int reversals;

  function new();
    front_slot    = '0;
    held_count    = '0;
    order_flipped = 1'b0;
    errors        = 0;
    words_seen    = 0;
    refused_full  = 0;
    refused_empty = 0;
    reversals     = 0;
    foreach (slot_value[i]) slot_value[i] = '0;
  endfunction

  // Apply one accepted word to the shadow deque and queue its answer.
  function void note_word(logic [1:0] op, logic signed [31:0] v);
    answer_t ans;
    logic    at_front;
    logic [3:0] slot;
    ans = '0;
    case (op)
      dwr_pkg::OP_INS_HEAD, dwr_pkg::OP_INS_TAIL: begin
        if (held_count < SLOTS) begin
          at_front = (op == dwr_pkg::OP_INS_HEAD) ^ order_flipped;
          if (at_front) begin
            front_slot = front_slot - 4'd1;
            slot_value[front_slot] = v;
          end else begin
            slot = front_slot + held_count[3:0];
            slot_value[slot] = v;
          end
          held_count = held_count + 5'd1;
          ans.ok = 1'b1;
        end else begin
          refused_full++;
        end
      end
      dwr_pkg::OP_REM_HEAD: begin
        if (held_count != 0) begin
          if (!order_flipped) begin
            ans.taken  = slot_value[front_slot];
            front_slot = front_slot + 4'd1;
          end else begin
            slot = front_slot + held_count[3:0] - 4'd1;
            ans.taken = slot_value[slot];
          end
          held_count = held_count - 5'd1;
          ans.ok = 1'b1;
        end else begin
          refused_empty++;
        end
      end
      default: begin
        order_flipped = !order_flipped;
        ans.ok = 1'b1;
        reversals++;
      end
    endcase
    ans.held = held_count;
    awaited_answers.push_back(ans);
    words_seen++;
  endfunction

  // Compare one result word with the oldest awaited answer.
  function void check_word(logic ok, logic signed [31:0] taken, logic [4:0] held);
    answer_t exp_ans;
    if (awaited_answers.size() == 0) begin
      $error("result word with no operation pending");
      errors++;
      return;
    end
    exp_ans = awaited_answers.pop_front();
    if (ok !== exp_ans.ok) begin
      $error("success: expected %0d, got %0d", exp_ans.ok, ok);
      errors++;
    end
    if (taken !== exp_ans.taken) begin
      $error("removed_value: expected %0d, got %0d", exp_ans.taken, taken);
      errors++;
    end
    if (held !== exp_ans.held) begin
      $error("occupancy: expected %0d, got %0d", exp_ans.held, held);
      errors++;
    end
  endfunction

  function int pending();
    return awaited_answers.size();
  endfunction
endclass

module tb_deque_with_reverse;
  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 338;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         opcode;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic               success;
  logic signed [31:0] removed_value;
  logic [4:0]         occupancy;

  deque_answer_checker checker_h;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_left;
  int cycle_count;

  deque_with_reverse #(.DEPTH(DEPTH)) u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .opcode        (opcode),
    .value         (value),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .success       (success),
    .removed_value (removed_value),
    .occupancy     (occupancy)
  );

  // Clock with a 20 ns period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: a requested hold-off wins, otherwise stall at random.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Record accepted words and check accepted results.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) checker_h.note_word(opcode, value);
      if (out_valid && out_ready) checker_h.check_word(success, removed_value, occupancy);
    end
  end

  // Offer one word, with random idle cycles first, and wait until it is taken.
  task automatic send_word(logic [1:0] op, logic signed [31:0] v);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= v;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every awaited result has come back.
  task automatic drain_all();
    @(negedge clk);
    in_valid <= 1'b0;
    while (checker_h.pending() != 0) @(negedge clk);
  endtask

  // Mostly random values, with the extremes mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // Bias toward inserts while filling and toward removes while draining.
  function automatic logic [1:0] pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (r < 15) return dwr_pkg::OP_REVERSE;
    if (filling) begin
      if (r < 45) return dwr_pkg::OP_INS_HEAD;
      if (r < 75) return dwr_pkg::OP_INS_TAIL;
      return dwr_pkg::OP_REM_HEAD;
    end
    if (r < 28) return dwr_pkg::OP_INS_HEAD;
    if (r < 40) return dwr_pkg::OP_INS_TAIL;
    return dwr_pkg::OP_REM_HEAD;
  endfunction

  initial begin
    bit filling;
    checker_h      = new();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 0;
    cycle_count    = 0;
    rst            = 1'b1;
    in_valid       = 1'b0;
    opcode         = dwr_pkg::OP_INS_HEAD;
    value          = '0;
    out_ready      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty store cases, extremes at both ends, removes in both orders.
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_REVERSE,  32'sd0);
    send_word(dwr_pkg::OP_REM_HEAD, -32'sd1);
    send_word(dwr_pkg::OP_REVERSE,  32'sd0);
    send_word(dwr_pkg::OP_INS_HEAD, 32'sh8000_0000);
    send_word(dwr_pkg::OP_INS_TAIL, 32'sh7fff_ffff);
    send_word(dwr_pkg::OP_INS_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_INS_TAIL, -32'sd1);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_REVERSE,  32'sd0);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_INS_HEAD, 32'sh5555_5555);
    send_word(dwr_pkg::OP_INS_TAIL, 32'shaaaa_aaaa);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_REVERSE,  32'sd0);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    send_word(dwr_pkg::OP_REM_HEAD, 32'sd0);
    drain_all();

    // Random phases with different idle and stall rates.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      filling = 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (i % 40 == 0) filling = ($urandom_range(2) != 0) ? !filling : filling;
        send_word(pick_op(filling), pick_value());
        // Long receiver hold-off while words keep coming, to back up the input.
        if (phase == 0 && i == 100) hold_left = 80;
        if (i == 200) drain_all();
      end
      drain_all();
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (checker_h.pending() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("Ran %0d words through four idle/stall mixes with a long output hold-off.",
             checker_h.words_seen);
    $display("Refused inserts when full: %0d, refused removes when empty: %0d, reversals: %0d.",
             checker_h.refused_full, checker_h.refused_empty, checker_h.reversals);
    if (checker_h.errors == 0 && checker_h.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
